>>> design/sc2a_pkg.sv
// Shared types, constants and keymap tables for the scancode-to-ASCII queue.
package sc2a_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CHAR_W      = 7;

	localparam logic       MODE_SCAN  = 1'b0;
	localparam logic       MODE_READ  = 1'b1;

	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_CAPS   = 7'h3A;
	localparam logic [7:0] KEY_BREAK  = 8'h80;

	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] scan_code;
	} cmd_t;

	typedef struct packed {
		char_t char_out;
		logic  char_valid;
		logic  queue_nonempty;
		logic  overflow_drop;
	} rsp_t;

	// Queue memory access issued by the control unit.
	typedef struct packed {
		logic  we;
		ptr_t  waddr;
		char_t wdata;
		logic  re;
		ptr_t  raddr;
	} ram_cmd_t;

	// Result flags that travel alongside the memory read.
	typedef struct packed {
		logic hit;
		logic nonempty;
		logic drop;
	} meta_t;

	function automatic ptr_t ptr_next(ptr_t p);
		ptr_t r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic char_t plain_char(logic [6:0] code);
		char_t c;
		unique case (code)
			7'd2:  c = 7'h31;
			7'd3:  c = 7'h32;
			7'd4:  c = 7'h33;
			7'd5:  c = 7'h34;
			7'd6:  c = 7'h35;
			7'd7:  c = 7'h36;
			7'd8:  c = 7'h37;
			7'd9:  c = 7'h38;
			7'd10: c = 7'h39;
			7'd11: c = 7'h30;
			7'd12: c = 7'h2D;
			7'd13: c = 7'h3D;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h71;
			7'd17: c = 7'h77;
			7'd18: c = 7'h65;
			7'd19: c = 7'h72;
			7'd20: c = 7'h74;
			7'd21: c = 7'h79;
			7'd22: c = 7'h75;
			7'd23: c = 7'h69;
			7'd24: c = 7'h6F;
			7'd25: c = 7'h70;
			7'd26: c = 7'h5B;
			7'd27: c = 7'h5D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h61;
			7'd31: c = 7'h73;
			7'd32: c = 7'h64;
			7'd33: c = 7'h66;
			7'd34: c = 7'h67;
			7'd35: c = 7'h68;
			7'd36: c = 7'h6A;
			7'd37: c = 7'h6B;
			7'd38: c = 7'h6C;
			7'd39: c = 7'h3B;
			7'd40: c = 7'h27;
			7'd41: c = 7'h60;
			7'd43: c = 7'h5C;
			7'd44: c = 7'h7A;
			7'd45: c = 7'h78;
			7'd46: c = 7'h63;
			7'd47: c = 7'h76;
			7'd48: c = 7'h62;
			7'd49: c = 7'h6E;
			7'd50: c = 7'h6D;
			7'd51: c = 7'h2C;
			7'd52: c = 7'h2E;
			7'd53: c = 7'h2F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic char_t upper_char(logic [6:0] code);
		char_t c;
		unique case (code)
			7'd2:  c = 7'h21;
			7'd3:  c = 7'h40;
			7'd4:  c = 7'h23;
			7'd5:  c = 7'h24;
			7'd6:  c = 7'h25;
			7'd7:  c = 7'h5E;
			7'd8:  c = 7'h26;
			7'd9:  c = 7'h2A;
			7'd10: c = 7'h28;
			7'd11: c = 7'h29;
			7'd12: c = 7'h5F;
			7'd13: c = 7'h2B;
			7'd14: c = 7'h08;
			7'd15: c = 7'h09;
			7'd16: c = 7'h51;
			7'd17: c = 7'h57;
			7'd18: c = 7'h45;
			7'd19: c = 7'h52;
			7'd20: c = 7'h54;
			7'd21: c = 7'h59;
			7'd22: c = 7'h55;
			7'd23: c = 7'h49;
			7'd24: c = 7'h4F;
			7'd25: c = 7'h50;
			7'd26: c = 7'h7B;
			7'd27: c = 7'h7D;
			7'd28: c = 7'h0A;
			7'd30: c = 7'h41;
			7'd31: c = 7'h53;
			7'd32: c = 7'h44;
			7'd33: c = 7'h46;
			7'd34: c = 7'h47;
			7'd35: c = 7'h48;
			7'd36: c = 7'h4A;
			7'd37: c = 7'h4B;
			7'd38: c = 7'h4C;
			7'd39: c = 7'h3A;
			7'd40: c = 7'h22;
			7'd41: c = 7'h7E;
			7'd43: c = 7'h7C;
			7'd44: c = 7'h5A;
			7'd45: c = 7'h58;
			7'd46: c = 7'h43;
			7'd47: c = 7'h56;
			7'd48: c = 7'h42;
			7'd49: c = 7'h4E;
			7'd50: c = 7'h4D;
			7'd51: c = 7'h3C;
			7'd52: c = 7'h3E;
			7'd53: c = 7'h3F;
			7'd55: c = 7'h2A;
			7'd57: c = 7'h20;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> design/sc2a_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sc2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/sc2a_ctrl.sv
// Keyboard modifier state, keymap lookup and queue pointer control.
module sc2a_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  sc2a_pkg::cmd_t    cmd,
	output sc2a_pkg::ram_cmd_t ram_cmd,
	output sc2a_pkg::meta_t   meta
);
	import sc2a_pkg::*;

	logic  shift_q, caps_q;
	ptr_t  wptr_q, rptr_q;

	logic  shift_d, caps_d;
	ptr_t  wptr_d, rptr_d;
	ptr_t  wnext;
	logic  release_code, upper;
	char_t plain_c, upper_c, ch;

	assign release_code = |(cmd.scan_code & KEY_BREAK);
	assign upper        = shift_q ^ caps_q;
	assign plain_c      = plain_char(cmd.scan_code[6:0]);
	assign upper_c      = upper_char(cmd.scan_code[6:0]);
	assign ch           = (upper && upper_c != '0) ? upper_c : plain_c;
	assign wnext        = ptr_next(wptr_q);

	always_comb begin
		shift_d       = shift_q;
		caps_d        = caps_q;
		wptr_d        = wptr_q;
		rptr_d        = rptr_q;
		ram_cmd.we    = 1'b0;
		ram_cmd.waddr = wptr_q;
		ram_cmd.wdata = ch;
		ram_cmd.re    = 1'b0;
		ram_cmd.raddr = rptr_q;
		meta.hit      = 1'b0;
		meta.drop     = 1'b0;
		if (go) begin
			if (cmd.mode == MODE_READ) begin
				if (wptr_q != rptr_q) begin
					ram_cmd.re = 1'b1;
					meta.hit   = 1'b1;
					rptr_d     = ptr_next(rptr_q);
				end
			end else if (release_code) begin
				if (cmd.scan_code[6:0] == KEY_LSHIFT || cmd.scan_code[6:0] == KEY_RSHIFT) begin
					shift_d = 1'b0;
				end
			end else if (cmd.scan_code[6:0] == KEY_LSHIFT ||
			             cmd.scan_code[6:0] == KEY_RSHIFT) begin
				shift_d = 1'b1;
			end else if (cmd.scan_code[6:0] == KEY_CAPS) begin
				caps_d = ~caps_q;
			end else if (ch != '0) begin
				// keep one slot free; drop when full
				if (wnext != rptr_q) begin
					ram_cmd.we = 1'b1;
					wptr_d     = wnext;
				end else begin
					meta.drop = 1'b1;
				end
			end
		end
		meta.nonempty = (wptr_d != rptr_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			wptr_q  <= '0;
			rptr_q  <= '0;
		end else begin
			shift_q <= shift_d;
			caps_q  <= caps_d;
			wptr_q  <= wptr_d;
			rptr_q  <= rptr_d;
		end
	end

endmodule

>>> design/scancode_to_ascii_queue_top.sv
// Top level: set 1 scancode decoder feeding a character queue in RAM.
// Pipeline: a result word passes through the queue RAM read stage, then the
// output register.
// Throughput: one command per cycle while the output is not stalled; the output register lets a new command
// enter while an earlier result is stalled.
// Reset: modifier flags and queue pointers clear; queue RAM contents are not cleared.
module scancode_to_ascii_queue_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sc2a_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sc2a_pkg::rsp_t rsp
);
	import sc2a_pkg::*;

	ram_cmd_t ram_cmd;
	meta_t    meta;
	char_t    rdata;
	logic     go;
	logic     out_free;
	logic     valid_s1;
	meta_t    meta_s1;
	logic     rsp_valid_q;
	rsp_t     rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !out_free;
	assign go        = cmd_valid && !cmd_stall;

	sc2a_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.cmd     (cmd),
		.ram_cmd (ram_cmd),
		.meta    (meta)
	);

	sc2a_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_cmd.wdata),
		.re    (ram_cmd.re),
		.raddr (ram_cmd.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// advance s1 whenever output can take it
			if (go) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			meta_s1 <= meta;
		end
		if (valid_s1 && out_free) begin
			rsp_q.char_out       <= meta_s1.hit ? rdata : '0;
			rsp_q.char_valid     <= meta_s1.hit;
			rsp_q.queue_nonempty <= meta_s1.nonempty;
			rsp_q.overflow_drop  <= meta_s1.drop;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_cmd.we && ram_cmd.re))
		else $error("queue RAM read and write issued together");

	a_popped_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.char_valid |-> rsp.char_out != '0)
		else $error("popped character is zero");

	a_pop_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.char_valid && rsp.overflow_drop))
		else $error("pop and overflow drop in one word");

	a_hit_nonempty_read: assert property (@(posedge clk) disable iff (!arst_n)
		go && cmd.mode == MODE_READ && !ram_cmd.re |=> valid_s1 && !meta_s1.nonempty)
		else $error("empty read left a nonempty queue");
`endif

endmodule

>>> bench/tb_scancode_to_ascii_queue_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the set 1 scancode decoder and its character queue.
module tb_scancode_to_ascii_queue_top;
	import sc2a_pkg::*;

	localparam int TIMEOUT_CYCLES = 200000;
	localparam int PHASE_WORDS    = 190;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	scancode_to_ascii_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// US keymap, plain and shifted
	char_t key_lower [128] = '{default: '0};
	char_t key_upper [128] = '{default: '0};

	// Decoder state as the block should hold it
	logic  shift_pressed = 1'b0;
	logic  caps_locked   = 1'b0;
	int    q_wr = 0;
	int    q_rd = 0;
	char_t queued_chars [QUEUE_DEPTH];
	rsp_t  expected_rsp [$];
	bit    word_acts;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_left     = 0;
	int cycles        = 0;
	int mismatches    = 0;
	int words_sent    = 0;
	int useful_words  = 0;
	int chars_read    = 0;
	int empty_reads   = 0;
	int chars_dropped = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic load_row(input int first, input string lo, input string hi);
		for (int i = 0; i < lo.len(); i++) begin
			key_lower[first + i] = char_t'(lo[i]);
			key_upper[first + i] = char_t'(hi[i]);
		end
	endtask

	// Decode one word against the tracked state and return the result it must give.
	function automatic rsp_t decode_key(cmd_t w);
		rsp_t       r;
		logic [6:0] code;
		char_t      ch;
		int         nxt;
		r = '0;
		code = w.scan_code[6:0];
		word_acts = 1'b1;
		if (w.mode == MODE_READ) begin
			if (q_wr != q_rd) begin
				r.char_out = queued_chars[q_rd];
				r.char_valid = 1'b1;
				q_rd = (q_rd + 1) % QUEUE_DEPTH;
				chars_read++;
			end else begin
				empty_reads++;
			end
		end else if ((w.scan_code & KEY_BREAK) != '0) begin
			// only a shift release changes anything
			if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
				shift_pressed = 1'b0;
			end else begin
				word_acts = 1'b0;
			end
		end else if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
			shift_pressed = 1'b1;
		end else if (code == KEY_CAPS) begin
			caps_locked = !caps_locked;
		end else begin
			ch = key_lower[code];
			if ((shift_pressed ^ caps_locked) && key_upper[code] != '0) begin
				ch = key_upper[code];
			end
			if (ch == '0) begin
				word_acts = 1'b0;
			end else begin
				// keep one slot free
				nxt = (q_wr + 1) % QUEUE_DEPTH;
				if (nxt != q_rd) begin
					queued_chars[q_wr] = ch;
					q_wr = nxt;
				end else begin
					r.overflow_drop = 1'b1;
					chars_dropped++;
				end
			end
		end
		r.queue_nonempty = (q_wr != q_rd);
		return r;
	endfunction

	function automatic cmd_t random_word(int read_pct);
		cmd_t       w;
		int         pick;
		logic [6:0] code;
		w.mode = MODE_SCAN;
		w.scan_code = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < read_pct) begin
			w.mode = MODE_READ;
		end else if (pick < read_pct + 5) begin
			w.scan_code = {1'b0, ($urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT)};
		end else if (pick < read_pct + 9) begin
			w.scan_code = KEY_BREAK | {1'b0, ($urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT)};
		end else if (pick < read_pct + 12) begin
			w.scan_code = {1'b0, KEY_CAPS};
		end else if (pick >= read_pct + 20) begin
			// typed key; the remaining band keeps the fully random byte
			do code = 7'($urandom_range(57, 2)); while (key_lower[code] == '0);
			w.scan_code = {1'b0, code};
		end
		return w;
	endfunction

	task automatic send_word(input cmd_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		expected_rsp.push_back(decode_key(w));
		words_sent++;
		if (word_acts) begin
			useful_words++;
		end
	endtask

	task automatic test_directed();
		send_word({MODE_READ, 8'hFF});    // read from an empty queue
		send_word({MODE_SCAN, 8'h1E});    // a
		send_word({MODE_SCAN, 8'h2A});    // left shift down
		send_word({MODE_SCAN, 8'h1E});    // A
		send_word({MODE_SCAN, 8'h02});    // !
		send_word({MODE_SCAN, 8'hAA});    // left shift up
		send_word({MODE_SCAN, 8'h36});    // right shift down
		send_word({MODE_SCAN, 8'h29});    // ~
		send_word({MODE_SCAN, 8'hB6});    // right shift up
		send_word({MODE_SCAN, 8'h3A});    // caps on
		send_word({MODE_SCAN, 8'h10});    // Q
		send_word({MODE_SCAN, 8'h2A});    // shift cancels caps
		send_word({MODE_SCAN, 8'h2C});    // z
		send_word({MODE_SCAN, 8'hAA});
		send_word({MODE_SCAN, 8'h3A});    // caps off
		send_word({MODE_SCAN, 8'h00});    // unmapped codes
		send_word({MODE_SCAN, 8'h7F});
		send_word({MODE_SCAN, 8'h9E});    // release of a plain key
		send_word({MODE_SCAN, 8'h0E});    // backspace
		send_word({MODE_SCAN, 8'h37});    // keypad star
		repeat (9) send_word({MODE_READ, 8'($urandom)});
	endtask

	task automatic test_queue_full();
		int drops_at_start;
		drops_at_start = chars_dropped;
		while (chars_dropped < drops_at_start + 3) begin
			send_word(random_word(0));
		end
		while (q_wr != q_rd) begin
			send_word({MODE_READ, 8'($urandom)});
		end
		send_word({MODE_READ, 8'($urandom)});
	endtask

	// Hold the result side off while words keep coming, so the input backs up.
	task automatic test_backpressure();
		hold_left = 300;
		repeat (80) send_word(random_word(30));
	endtask

	task automatic test_random();
		int idle_set  [4] = '{0, 49, 0, 15};
		int stall_set [4] = '{0, 0, 49, 15};
		int read_set  [4] = '{3, 25, 50, 75};
		int phase_start;
		int burst;
		int read_pct;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			rsp_stall_pct = stall_set[p];
			phase_start = useful_words;
			while (useful_words < phase_start + PHASE_WORDS) begin
				// bursts with few reads fill the queue, read-heavy ones drain it
				burst = $urandom_range(120, 20);
				read_pct = read_set[$urandom_range(3)];
				repeat (burst) send_word(random_word(read_pct));
			end
		end
		send_idle_pct = 0;
		rsp_stall_pct = 0;
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result word %h", rsp);
				end
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.char_out !== want.char_out || rsp.char_valid !== want.char_valid
						|| rsp.queue_nonempty !== want.queue_nonempty
						|| rsp.overflow_drop !== want.overflow_drop) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected char=%h valid=%b nonempty=%b drop=%b",
							want.char_out, want.char_valid, want.queue_nonempty,
							want.overflow_drop);
						$display("          actual   char=%h valid=%b nonempty=%b drop=%b",
							rsp.char_out, rsp.char_valid, rsp.queue_nonempty,
							rsp.overflow_drop);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				expected_rsp.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		load_row(2, "1234567890-=", "!@#$%^&*()_+");
		load_row(16, "qwertyuiop[]", "QWERTYUIOP{}");
		load_row(30, "asdfghjkl;'", "ASDFGHJKL:\"");
		load_row(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
		key_lower[14] = 7'h08; key_upper[14] = 7'h08;
		key_lower[15] = 7'h09; key_upper[15] = 7'h09;
		key_lower[28] = 7'h0A; key_upper[28] = 7'h0A;
		key_lower[41] = 7'h60; key_upper[41] = 7'h7E;
		key_lower[55] = 7'h2A; key_upper[55] = 7'h2A;
		key_lower[57] = 7'h20; key_upper[57] = 7'h20;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_queue_full();
		test_backpressure();
		test_random();

		cmd_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d words (%0d with an effect) over four idle/stall mixes.",
			words_sent, useful_words);
		$display("Read back %0d characters, %0d empty reads, %0d dropped on a full queue.",
			chars_read, empty_reads, chars_dropped);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> scancode_to_ascii_queue_top.f
design/sc2a_pkg.sv
design/sc2a_ram.sv
design/sc2a_ctrl.sv
design/scancode_to_ascii_queue_top.sv
bench/tb_scancode_to_ascii_queue_top.sv
